FILE: rtl/pon_pkg.sv
// shared types and constants for the octave gradient noise block
package pon_pkg;

	localparam int FB = 16;

	typedef enum logic [0:0] {
		REG_OCTAVE_COUNT = 1'b0,
		REG_UNIT_OUTPUT  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FADE,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_H5,
		ST_GRAD,
		ST_LERP,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       fade;
		logic [3:0] hstep;
		logic       hrun;
		logic [2:0] gidx;
		logic       grun;
		logic [2:0] lidx;
		logic       lrun;
		logic       acc;
		logic       fin;
	} cmd_t;

endpackage

FILE: rtl/pon_if.sv
// valid/ready channel carrying one word of payload
interface pon_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/pon_ctrl.sv
// sequencer for the noise datapath
module pon_ctrl import pon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [4:0] octs,
	input  logic       out_free,
	output logic       busy,
	output cmd_t       cmd
);
	state_t     state_q, state_d;
	logic [3:0] sub_q, sub_d;
	logic [4:0] oct_q, oct_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q <= '0;
			oct_q <= '0;
		end else begin
			state_q <= state_d;
			sub_q <= sub_d;
			oct_q <= oct_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sub_d = sub_q;
		oct_d = oct_q;
		unique case (state_q)
			ST_IDLE: begin
				oct_d = '0;
				sub_d = '0;
				if (start) state_d = (octs == 5'd0) ? ST_DONE : ST_FADE;
			end
			ST_FADE: begin
				sub_d = sub_q + 4'd1;
				if (sub_q == 4'd11) begin
					sub_d = '0;
					state_d = ST_H0;
				end
			end
			ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5: begin
				sub_d = sub_q + 4'd1;
				if (sub_q == 4'd13) begin
					sub_d = '0;
					state_d = ST_GRAD;
				end
			end
			ST_GRAD: begin
				sub_d = sub_q + 4'd1;
				if (sub_q == 4'd7) begin
					sub_d = '0;
					state_d = ST_LERP;
				end
			end
			ST_LERP: begin
				sub_d = sub_q + 4'd1;
				if (sub_q == 4'd13) begin
					sub_d = '0;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				oct_d = oct_q + 5'd1;
				state_d = (oct_q + 5'd1 == octs) ? ST_DONE : ST_FADE;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_FADE: begin
				cmd.fade = 1'b1;
				cmd.hstep = sub_q;
			end
			ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5: begin
				cmd.hrun = 1'b1;
				cmd.hstep = sub_q;
			end
			ST_GRAD: begin
				cmd.grun = 1'b1;
				cmd.gidx = sub_q[2:0];
			end
			ST_LERP: begin
				cmd.lrun = 1'b1;
				cmd.lidx = sub_q[3:1];
				cmd.hstep = sub_q;
			end
			ST_ACC: cmd.acc = 1'b1;
			ST_DONE: cmd.fin = out_free;
			default: ;
		endcase
	end
endmodule

FILE: rtl/pon_dp.sv
// table, fade, hashing, gradients, lerps, octave sum and final scaling
module pon_dp import pon_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               tw_en,
	input  logic [7:0]         tw_idx,
	input  logic [7:0]         tw_val,
	input  logic [31:0]        x_in,
	input  logic [31:0]        y_in,
	input  logic [31:0]        z_in,
	input  logic               unit,
	input  logic [4:0]         oct_idx,
	output logic signed [18:0] result
);
	localparam logic signed [39:0] ONE = 40'sd65536;
	logic [7:0] mem [256];
	logic [7:0] rd_q;
	logic [7:0] ra;
	logic [31:0] xr_q, yr_q, zr_q;
	logic signed [39:0] u_q, v_q, w_q, t_q, p_q;
	logic [7:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	logic [7:0] hs_q [8];
	logic signed [39:0] g_q [8];
	logic signed [39:0] l_q [7];
	logic signed [44:0] sum_q;
	logic signed [23:0] ma, mb;
	logic signed [47:0] prod;
	logic signed [39:0] mres;
	logic [7:0] cx, cy, cz;
	logic signed [39:0] fx, fy, fz, ff;
	logic [1:0] fax, fst;
	logic [2:0] gi;
	logic [3:0] h;
	logic signed [39:0] px, py, pz, gu, gv, gval;
	logic [3:0] hidx;
	logic signed [44:0] fin;

	// one shared multiplier, floor shift of the product
	assign prod = ma * mb;
	assign mres = 40'($signed(prod[47:16]));

	assign cx = xr_q[23:16];
	assign cy = yr_q[23:16];
	assign cz = zr_q[23:16];
	assign fx = {24'd0, xr_q[15:0]};
	assign fy = {24'd0, yr_q[15:0]};
	assign fz = {24'd0, zr_q[15:0]};

	// fade: four multiplier steps per axis
	assign fax = cmd.hstep[3:2];
	assign fst = cmd.hstep[1:0];
	always_comb begin
		unique case (fax)
			2'd0: ff = fx;
			2'd1: ff = fy;
			default: ff = fz;
		endcase
	end

	// table read address per hashing step
	always_comb begin
		ra = '0;
		if (cmd.hrun) begin
			unique case (cmd.hstep)
				4'd0: ra = cx;
				4'd1: ra = cx + 8'd1;
				4'd2: ra = a_q;
				4'd3: ra = a_q + 8'd1;
				4'd4: ra = b_q;
				4'd5: ra = b_q + 8'd1;
				4'd6: ra = aa_q;
				4'd7: ra = ba_q;
				4'd8: ra = ab_q;
				4'd9: ra = bb_q;
				4'd10: ra = aa_q + 8'd1;
				4'd11: ra = ba_q + 8'd1;
				4'd12: ra = ab_q + 8'd1;
				default: ra = bb_q + 8'd1;
			endcase
		end
	end
	assign hidx = cmd.hstep - 4'd1;

	always_ff @(posedge clk) begin
		if (tw_en) mem[tw_idx] <= tw_val;
		rd_q <= mem[ra];
	end

	// gradient for corner gi
	assign gi = cmd.gidx;
	assign h = hs_q[gi][3:0];
	assign px = gi[0] ? fx - ONE : fx;
	assign py = gi[1] ? fy - ONE : fy;
	assign pz = gi[2] ? fz - ONE : fz;
	assign gu = (h < 4'd8) ? px : py;
	assign gv = (h < 4'd4) ? py : ((h == 4'd12 || h == 4'd14) ? px : pz);
	assign gval = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		if (cmd.fade) begin
			unique case (fst)
				2'd0: begin ma = ff[23:0]; mb = 24'(6 * ff - 15 * ONE); end
				2'd1: begin ma = ff[23:0]; mb = ff[23:0]; end
				2'd2: begin ma = p_q[23:0]; mb = ff[23:0]; end
				default: begin ma = p_q[23:0]; mb = 24'(t_q + 10 * ONE); end
			endcase
		end else if (cmd.lrun) begin
			unique case (cmd.lidx)
				3'd0: begin ma = u_q[23:0]; mb = 24'(g_q[1] - g_q[0]); end
				3'd1: begin ma = u_q[23:0]; mb = 24'(g_q[3] - g_q[2]); end
				3'd2: begin ma = u_q[23:0]; mb = 24'(g_q[5] - g_q[4]); end
				3'd3: begin ma = u_q[23:0]; mb = 24'(g_q[7] - g_q[6]); end
				3'd4: begin ma = v_q[23:0]; mb = 24'(l_q[1] - l_q[0]); end
				3'd5: begin ma = v_q[23:0]; mb = 24'(l_q[3] - l_q[2]); end
				default: begin ma = w_q[23:0]; mb = 24'(l_q[5] - l_q[4]); end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			if (cmd.load) sum_q <= '0;
			else if (cmd.acc) sum_q <= sum_q + 45'(l_q[6] >>> oct_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xr_q <= x_in;
			yr_q <= y_in;
			zr_q <= z_in;
		end else if (cmd.acc) begin
			xr_q <= xr_q << 1;
			yr_q <= yr_q << 1;
			zr_q <= zr_q << 1;
		end
		if (cmd.fade) begin
			unique case (fst)
				2'd0: t_q <= mres;
				2'd1, 2'd2: p_q <= mres;
				default: begin
					unique case (fax)
						2'd0: u_q <= mres;
						2'd1: v_q <= mres;
						default: w_q <= mres;
					endcase
				end
			endcase
		end
		if (cmd.hrun && cmd.hstep != 4'd0) begin
			unique case (hidx)
				4'd0: a_q <= rd_q + cy;
				4'd1: b_q <= rd_q + cy;
				4'd2: aa_q <= rd_q + cz;
				4'd3: ab_q <= rd_q + cz;
				4'd4: ba_q <= rd_q + cz;
				4'd5: bb_q <= rd_q + cz;
				4'd6: hs_q[0] <= rd_q;
				4'd7: hs_q[1] <= rd_q;
				4'd8: hs_q[2] <= rd_q;
				4'd9: hs_q[3] <= rd_q;
				4'd10: hs_q[4] <= rd_q;
				4'd11: hs_q[5] <= rd_q;
				default: hs_q[6] <= rd_q;
			endcase
		end
		if (cmd.grun) begin
			if (gi == 3'd0) hs_q[7] <= rd_q;
			g_q[gi] <= gval;
		end
		if (cmd.lrun && !cmd.hstep[0]) begin
			unique case (cmd.lidx)
				3'd0: l_q[0] <= g_q[0] + mres;
				3'd1: l_q[1] <= g_q[2] + mres;
				3'd2: l_q[2] <= g_q[4] + mres;
				3'd3: l_q[3] <= g_q[6] + mres;
				3'd4: l_q[4] <= l_q[0] + mres;
				3'd5: l_q[5] <= l_q[2] + mres;
				default: l_q[6] <= l_q[4] + mres;
			endcase
		end
	end

	// final scaling and saturation
	always_comb begin
		fin = unit ? (sum_q >>> 1) + 45'sd32768 : sum_q;
		if (fin > 45'sd262143) result = 19'sd262143;
		else if (fin < -45'sd262144) result = -19'sd262144;
		else result = fin[18:0];
	end
endmodule

FILE: rtl/perlin_octave_noise_3d.sv
// top level of the octave gradient noise block
// channel | dir | payload
// in_ch   | in  | mode, x/y/z coords, table index and value
// out_ch  | out | noise_value
// cfg_ch  | in  | register index, write data
// table writes are taken only while idle; a point with zero octaves goes straight to the result
// per octave: fade, hashing on the single table read port, gradients, lerps, accumulate
// reset initialises control and config registers; table contents are undefined until written
// results wait in an output register; the engine holds a new result until the register is free
module perlin_octave_noise_3d import pon_pkg::*; #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic clk,
	input  logic arst_n,
	pon_if.sink   in_ch,
	pon_if.source out_ch,
	pon_if.sink   cfg_ch
);
	logic [3:0] octave_count_q;
	logic       unit_output_q;
	logic       busy, start, tw_en;
	logic [4:0] octs;
	logic signed [18:0] res;
	cmd_t cmd;
	logic [4:0] oct_q;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 4'd1;
			unit_output_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (reg_idx_t'(cfg_ch.data[8]))
				REG_OCTAVE_COUNT: if (cfg_ch.data[39:9] == 0) octave_count_q <= cfg_ch.data[3:0];
				REG_UNIT_OUTPUT: if (cfg_ch.data[39:9] == 0) unit_output_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	assign octs = ({1'b0, octave_count_q} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
		: {1'b0, octave_count_q};
	assign in_ch.ready = !busy;
	assign start = in_ch.valid && !busy && !in_ch.data[0];
	assign tw_en = in_ch.valid && !busy && in_ch.data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
			oct_q <= '0;
		end else begin
			if (cmd.load) oct_q <= '0;
			else if (cmd.acc) oct_q <= oct_q + 5'd1;
			if (cmd.fin) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) if (cmd.fin) out_ch.data <= res;

	pon_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .octs(octs),
		.out_free(!out_ch.valid || out_ch.ready), .busy(busy), .cmd(cmd)
	);

	pon_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .tw_en(tw_en),
		.tw_idx(in_ch.data[104:97]), .tw_val(in_ch.data[112:105]),
		.x_in(in_ch.data[32:1]), .y_in(in_ch.data[64:33]), .z_in(in_ch.data[96:65]),
		.unit(unit_output_q), .oct_idx(oct_q), .result(res)
	);
endmodule

FILE: dv/tb.sv
// testbench for the octave gradient noise block: table loads, points and register phases
`timescale 1ns / 100ps
module tb;
	import pon_pkg::*;

	localparam int IN_W = 1 + 3 * 32 + 8 + 8;
	localparam int OUT_W = 19;
	localparam int CFG_W = 32 + 8;
	localparam int WATCHDOG = 6000;
	localparam int SETTLE = 40;

	typedef struct packed {
		logic [7:0]  table_value;
		logic [7:0]  table_index;
		logic [31:0] z_coord;
		logic [31:0] y_coord;
		logic [31:0] x_coord;
		logic        mode;
	} point_word_t;

	class noise_scoreboard;
		logic [7:0] perm[256];
		int unsigned octaves = 1;
		bit unit_out = 0;
		logic [OUT_W-1:0] pending[$];
		int errors = 0;

		function longint fmul(longint a, longint b);
			return (a * b) >>> FB;
		endfunction

		function longint fade(longint t);
			longint inner, t3;
			inner = fmul(t, 6 * t - 15 * 65536) + 10 * 65536;
			t3 = fmul(fmul(t, t), t);
			return fmul(t3, inner);
		endfunction

		function longint lerp(longint t, longint a, longint b);
			return a + fmul(t, b - a);
		endfunction

		function longint grad(int unsigned hash, longint x, longint y, longint z);
			int unsigned h;
			longint u, v;
			h = hash & 15;
			u = (h < 8) ? x : y;
			v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
			return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
		endfunction

		function int unsigned pt(int unsigned i);
			return perm[i & 255];
		endfunction

		function longint octave_noise(logic [31:0] xr, logic [31:0] yr, logic [31:0] zr);
			int unsigned cx, cy, cz, a, aa, ab, b, ba, bb;
			longint fx, fy, fz, gx, gy, gz, u, v, w, l0, l1;
			cx = xr[23:16]; cy = yr[23:16]; cz = zr[23:16];
			fx = xr[15:0]; fy = yr[15:0]; fz = zr[15:0];
			gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
			u = fade(fx); v = fade(fy); w = fade(fz);
			a = pt(cx) + cy; aa = pt(a) + cz; ab = pt(a + 1) + cz;
			b = pt(cx + 1) + cy; ba = pt(b) + cz; bb = pt(b + 1) + cz;
			l0 = lerp(v, lerp(u, grad(pt(aa), fx, fy, fz), grad(pt(ba), gx, fy, fz)),
				lerp(u, grad(pt(ab), fx, gy, fz), grad(pt(bb), gx, gy, fz)));
			l1 = lerp(v, lerp(u, grad(pt(aa + 1), fx, fy, gz), grad(pt(ba + 1), gx, fy, gz)),
				lerp(u, grad(pt(ab + 1), fx, gy, gz), grad(pt(bb + 1), gx, gy, gz)));
			return lerp(w, l0, l1);
		endfunction

		function void set_reg(reg_idx_t idx, logic [3:0] val);
			if (idx == REG_OCTAVE_COUNT) octaves = val;
			else unit_out = val[0];
		endfunction

		function void note(point_word_t p);
			logic [31:0] xr, yr, zr;
			longint sum;
			int unsigned n;
			if (p.mode) begin
				perm[p.table_index] = p.table_value;
				return;
			end
			xr = p.x_coord; yr = p.y_coord; zr = p.z_coord;
			n = (octaves > 8) ? 8 : octaves;
			sum = 0;
			for (int i = 0; i < n; i++) begin
				sum += octave_noise(xr, yr, zr) >>> i;
				xr = xr << 1; yr = yr << 1; zr = zr << 1;
			end
			if (unit_out) sum = (sum >>> 1) + 32768;
			if (sum > 262143) sum = 262143;
			if (sum < -262144) sum = -262144;
			pending.push_back(sum[OUT_W-1:0]);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected noise_value %0d", $signed(got)));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report($sformatf("noise_value got %0d want %0d", $signed(got), $signed(want)));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	pon_if #(IN_W) in_ch();
	pon_if #(OUT_W) out_ch();
	pon_if #(CFG_W) cfg_ch();
	noise_scoreboard sb = new();
	bit calm = 0;
	int idle_cycles = 0;

	perlin_octave_noise_3d u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_ch(cfg_ch));

	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		out_ch.ready = 0;
	end

	always @(negedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task send(point_word_t p);
		while (!calm && $urandom_range(99) < 19) begin
			in_ch.valid = 0;
			@(negedge clk);
		end
		in_ch.valid = 1;
		in_ch.data = p;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(p);
		@(negedge clk);
		in_ch.valid = 0;
	endtask

	task write_reg(reg_idx_t idx, logic [3:0] val);
		while (sb.pending.size() != 0) @(negedge clk);
		in_ch.valid = 0;
		repeat (SETTLE) @(negedge clk);
		cfg_ch.valid = 1;
		cfg_ch.data = {32'(idx), 8'(val)};
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	function point_word_t table_word(logic [7:0] idx, logic [7:0] val);
		point_word_t p;
		p = '0;
		p.mode = 1;
		p.x_coord = $urandom;
		p.y_coord = $urandom;
		p.z_coord = $urandom;
		p.table_index = idx;
		p.table_value = val;
		return p;
	endfunction

	function point_word_t point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_word_t p;
		p = '0;
		p.x_coord = x;
		p.y_coord = y;
		p.z_coord = z;
		p.table_index = 8'($urandom);
		p.table_value = 8'($urandom);
		return p;
	endfunction

	function logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0040_0000);
			2: return -$urandom_range(32'h0040_0000);
			default: return 32'({8'($urandom_range(255)), 16'($urandom)})
				| 32'($urandom_range(1));
		endcase
	endfunction

	task random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 12)
				send(table_word(8'($urandom), 8'($urandom)));
			else
				send(point(rand_coord(), rand_coord(), rand_coord()));
		end
	endtask

	initial begin
		logic [7:0] shuffle[256];
		int j;
		logic [7:0] t;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = int'($urandom_range(i));
			t = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = t;
		end
		calm = 1;
		for (int i = 0; i < 256; i++) send(table_word(8'(i), shuffle[i]));
		calm = 0;

		// plain noise at reset settings, then field extremes
		send(point(0, 0, 0));
		send(point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send(point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send(point(32'hffff_ffff, 32'h0000_ffff, 32'h0001_0000));
		send(point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
		send(point(32'h00ff_ffff, 32'h0100_0000, 32'hff00_0001));
		send(table_word(8'hff, 8'h00));
		send(table_word(8'h00, 8'hff));
		send(point(32'h00ff_8000, 32'h0000_4000, 32'h00ff_c000));
		write_reg(REG_OCTAVE_COUNT, 4'd0);
		write_reg(REG_UNIT_OUTPUT, 4'd1);
		send(point(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f));
		write_reg(REG_OCTAVE_COUNT, 4'd8);
		send(point(32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555));
		send(point(32'h0000_c000, 32'h0003_4000, 32'hfffd_2000));
		write_reg(REG_OCTAVE_COUNT, 4'd15);
		write_reg(REG_UNIT_OUTPUT, 4'd0);
		send(point(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000));
		send(point(32'h0000_7fff, 32'hffff_8001, 32'h00ff_0000));

		write_reg(REG_OCTAVE_COUNT, 4'd1);
		random_items(60);
		write_reg(REG_UNIT_OUTPUT, 4'd1);
		calm = 1;
		random_items(30);
		calm = 0;
		write_reg(REG_OCTAVE_COUNT, 4'd8);
		random_items(30);
		write_reg(REG_OCTAVE_COUNT, 4'd3);
		write_reg(REG_UNIT_OUTPUT, 4'd0);
		random_items(50);
		write_reg(REG_OCTAVE_COUNT, 4'd0);
		random_items(10);
		write_reg(REG_OCTAVE_COUNT, 4'd9);
		random_items(20);
		write_reg(REG_OCTAVE_COUNT, 4'd2);
		random_items(30);

		in_ch.valid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/pon_pkg.sv
rtl/pon_if.sv
rtl/pon_ctrl.sv
rtl/pon_dp.sv
rtl/perlin_octave_noise_3d.sv
dv/tb.sv
